### sv/aco_pkg.sv
package aco_pkg;

	// frame store geometry
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(STORE_DEPTH);

	// field widths
	localparam int POS_X_W = 9;
	localparam int POS_Y_W = 8;
	localparam int PIX_W   = 8;
	localparam int FW_W    = 10;
	localparam int FH_W    = 9;
	localparam int SX_W    = 10;
	localparam int SY_W    = 9;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;

	// luma weights, bt.601 in 256ths (sum 256, shift of 8)
	localparam int LUMA_KR = 77;
	localparam int LUMA_KG = 150;
	localparam int LUMA_KB = 29;
	localparam int LUMA_SHIFT = 8;
	localparam int LUMA_SUM_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_SHIFT_X      = 2'd2,
		REG_SHIFT_Y      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_COMPOSE = 1'b1
	} item_mode_t;

endpackage

### sv/anaglyph_compose_offset_unit.sv
// grayscale red-cyan anaglyph composer with a programmable right-eye offset
//
// input channel (in_valid / in_stall): one pixel request per cycle unless stalled.
// mode load stores the luma of a right-eye pixel in the frame store at (pos_x, pos_y);
// mode compose takes a left-eye pixel and fetches the stored right luma at
// (pos_x - shift_x, pos_y - shift_y), clamped to the frame edges.
// output channel (out_valid / out_stall): one request per compose item inside
// the frame: out_red = left luma, out_green = out_blue = right luma. loads and
// pixels outside the frame give nothing.
// pipeline: a compose request is registered in stage one, and its store read and
// left luma are registered in stage two, where the result is presented.
// throughput: one request per cycle while no held result stalls stage one, set by the
// single read-or-write access to the frame store each item makes in stage one.
// stalling: while out_stall holds a result, stage one waits and in_stall rises
// only once stage one is occupied, so one further request is absorbed.
// reset: config returns to 400x240 with zero offset and the pipeline empties.
// the frame store is not cleared; an entry must be loaded before a compose reads it.
// the user writes config via cfg_we/cfg_index/cfg_data only while idle (not enforced).
module anaglyph_compose_offset_unit
	import aco_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input requests
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [POS_X_W-1:0]    pos_x,
	input  logic [POS_Y_W-1:0]    pos_y,
	input  logic [PIX_W-1:0]      pix_red,
	input  logic [PIX_W-1:0]      pix_green,
	input  logic [PIX_W-1:0]      pix_blue,
	// result requests
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      out_red,
	output logic [PIX_W-1:0]      out_green,
	output logic [PIX_W-1:0]      out_blue
);

	// configuration registers
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic [SX_W-1:0] shift_x_q;
	logic [SY_W-1:0] shift_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(400);
			frame_height_q <= FH_W'(240);
			shift_x_q      <= '0;
			shift_y_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				REG_SHIFT_X:      shift_x_q      <= cfg_data[SX_W-1:0];
				REG_SHIFT_Y:      shift_y_q      <= cfg_data[SY_W-1:0];
				default: ;
			endcase
		end
	end

	// active frame, limited by the store geometry
	logic [FW_W-1:0] w_act;
	logic [FH_W-1:0] h_act;

	assign w_act = (32'(frame_width_q) > MAX_WIDTH) ? FW_W'(MAX_WIDTH) : frame_width_q;
	assign h_act = (32'(frame_height_q) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT) : frame_height_q;

	// pipeline control
	logic v_s1;
	logic mode_s1;
	logic advance;
	logic ld_s1;
	logic in_accept;
	logic out_valid_s2;

	assign advance   = !out_valid_s2 || !out_stall;
	assign ld_s1     = !v_s1 || advance;
	assign in_stall  = !ld_s1;
	assign in_accept = in_valid && !in_stall;

	// frame check, pixels outside are dropped here
	logic in_frame;

	assign in_frame = ({1'b0, pos_x} < w_act) && ({1'b0, pos_y} < h_act);

	// source position with edge clamp
	localparam int DX_W = POS_X_W + 3;
	localparam int DY_W = POS_Y_W + 3;

	logic signed [DX_W-1:0] dx;
	logic signed [DY_W-1:0] dy;
	logic [POS_X_W-1:0]     rx;
	logic [POS_Y_W-1:0]     ry;

	assign dx = $signed({3'b000, pos_x}) - $signed({{2{shift_x_q[SX_W-1]}}, shift_x_q});
	assign dy = $signed({3'b000, pos_y}) - $signed({{2{shift_y_q[SY_W-1]}}, shift_y_q});

	always_comb begin
		if (dx < 0) begin
			rx = '0;
		end else if (dx >= $signed({2'b00, w_act})) begin
			rx = POS_X_W'(w_act - FW_W'(1));
		end else begin
			rx = dx[POS_X_W-1:0];
		end
		if (dy < 0) begin
			ry = '0;
		end else if (dy >= $signed({2'b00, h_act})) begin
			ry = POS_Y_W'(h_act - FH_W'(1));
		end else begin
			ry = dy[POS_Y_W-1:0];
		end
	end

	// store address: row-major with a fixed row pitch
	logic [ADDR_W-1:0] dst_addr;
	logic [ADDR_W-1:0] src_addr;

	assign dst_addr = ADDR_W'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));
	assign src_addr = ADDR_W'(32'(ry) * MAX_WIDTH + 32'(rx));

	// luma of the incoming pixel, either eye
	logic [LUMA_SUM_W-1:0] luma_sum;
	logic [PIX_W-1:0]      luma;

	assign luma_sum = LUMA_SUM_W'(LUMA_KR) * LUMA_SUM_W'(pix_red)
	                + LUMA_SUM_W'(LUMA_KG) * LUMA_SUM_W'(pix_green)
	                + LUMA_SUM_W'(LUMA_KB) * LUMA_SUM_W'(pix_blue);
	assign luma     = luma_sum[LUMA_SHIFT +: PIX_W];

	// stage one: address and luma ready for the store access
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0]  luma_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= in_accept && in_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_s1 <= mode;
			addr_s1 <= (item_mode_t'(mode) == MODE_COMPOSE) ? src_addr : dst_addr;
			luma_s1 <= luma;
		end
	end

	// frame store access, one per item, issued as the item leaves stage one
	logic             ram_we;
	logic             ram_re;
	logic [PIX_W-1:0] ram_rdata;

	assign ram_we = advance && v_s1 && (item_mode_t'(mode_s1) == MODE_LOAD);
	assign ram_re = advance && v_s1 && (item_mode_t'(mode_s1) == MODE_COMPOSE);

	aco_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata(luma_s1),
		.re   (ram_re),
		.raddr(addr_s1),
		.rdata(ram_rdata)
	);

	// stage two: output register, read data holds while stalled since no read issues
	logic [PIX_W-1:0] out_red_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			out_red_s2 <= luma_s1;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_red   = out_red_s2;
	assign out_green = ram_rdata;
	assign out_blue  = ram_rdata;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("input stalled with stage one empty");

	a_drop_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !in_frame) |=> !v_s1)
		else $error("pixel outside the frame entered the pipeline");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> !out_valid)
		else $error("load produced a result");

	a_compose_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> out_valid)
		else $error("compose read lost its result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !ram_re && !ram_we)
		else $error("store accessed while the output is held");

endmodule

### sv/aco_ram.sv
module aco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
